### rtl/core/brbe_pkg.sv
// ----------------------------------------------------------------------------
// Blob range and bearing package
// Shared types, register indexes and constants for the range and bearing core.
// ----------------------------------------------------------------------------
package brbe_pkg;

    typedef struct packed {
        logic [8:0] blob_x;
        logic [7:0] blob_height;
        logic [8:0] blob_width;
        logic [2:0] blob_signature;
        logic       frame_last;
    } blob_in_t;

    typedef struct packed {
        logic              accepted;
        logic [21:0]       distance_q4;
        logic signed [15:0] bearing_q15;
        logic [2:0]        signature_out;
        logic [6:0]        accepted_so_far;
        logic              frame_done;
    } blob_out_t;

    typedef struct packed {
        logic load;
        logic step;
    } brbe_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_FIN
    } brbe_state_t;

    localparam logic [3:0] CFG_X_CENTER   = 4'd0;
    localparam logic [3:0] CFG_TGT_HEIGHT = 4'd1;
    localparam logic [3:0] CFG_RATIO_LOW  = 4'd2;
    localparam logic [3:0] CFG_RATIO_HIGH = 4'd3;

    localparam int DIVIDEND_W   = 31;
    localparam int DIVISOR_W    = 17;
    localparam int QUOT_W       = 22;
    localparam int DIV_STEPS    = QUOT_W;
    localparam int CORDIC_STEPS = 17;
    localparam int STEP_W       = 5;
    localparam int CX_W         = 29;
    localparam int CY_W         = 30;
    localparam int Z_W          = 18;

    localparam logic [30:0] DIST_NUM2   = 31'd1792000;
    localparam logic [30:0] DIST_DEN    = 31'd243;
    localparam logic [16:0] DIST_DEN2   = 17'd486;
    localparam logic [21:0] DIST_MAX    = 22'd4194303;
    localparam logic [28:0] CORDIC_X0   = 29'd57344000;
    localparam logic [17:0] BEAR_GAIN   = 18'd243;

    function automatic logic [15:0] atan_q16(input logic [STEP_W-1:0] i);
        logic [15:0] a;
        case (i)
            5'd0:    a = 16'd51472;
            5'd1:    a = 16'd30386;
            5'd2:    a = 16'd16055;
            5'd3:    a = 16'd8150;
            5'd4:    a = 16'd4091;
            5'd5:    a = 16'd2047;
            5'd6:    a = 16'd1024;
            5'd7:    a = 16'd512;
            5'd8:    a = 16'd256;
            5'd9:    a = 16'd128;
            5'd10:   a = 16'd64;
            5'd11:   a = 16'd32;
            5'd12:   a = 16'd16;
            5'd13:   a = 16'd8;
            5'd14:   a = 16'd4;
            5'd15:   a = 16'd2;
            5'd16:   a = 16'd1;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

endpackage

### rtl/core/brbe_div.sv
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle by shifting the dividend through the
// partial remainder.
// ----------------------------------------------------------------------------
module brbe_div
    import brbe_pkg::*;
(
    input  logic                  clk,
    input  brbe_ctl_t             ctl,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [QUOT_W-1:0]     quotient
);

    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [QUOT_W-1:0]    dq_reg;
    logic [QUOT_W-1:0]    dq_next;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [DIVISOR_W-1:0] dvs_next;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    // The quotient is known to fit its width, so the top dividend bits are
    // already below the divisor and seed the remainder directly.
    always_comb
    begin
        trial    = {rem_reg, dq_reg[QUOT_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = rem_reg;
        dq_next  = dq_reg;
        dvs_next = dvs_reg;
        if (ctl.load)
        begin
            rem_next = {{(DIVISOR_W-(DIVIDEND_W-QUOT_W)){1'b0}},
                        dividend[DIVIDEND_W-1:QUOT_W]};
            dq_next  = dividend[QUOT_W-1:0];
            dvs_next = divisor;
        end
        else if (ctl.step)
        begin
            rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            dq_next  = {dq_reg[QUOT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = dq_reg;

endmodule

### rtl/core/brbe_cordic.sv
// ----------------------------------------------------------------------------
// Iterative CORDIC arctangent
// Vectoring mode, one rotation per cycle, angle accumulated in Q16 radians.
// ----------------------------------------------------------------------------
module brbe_cordic
    import brbe_pkg::*;
(
    input  logic                   clk,
    input  brbe_ctl_t              ctl,
    input  logic [STEP_W-1:0]      idx,
    input  logic [8:0]             mag,
    output logic signed [Z_W-1:0]  angle
);

    logic [CX_W-1:0]        cx_reg;
    logic [CX_W-1:0]        cx_next;
    logic signed [CY_W-1:0] cy_reg;
    logic signed [CY_W-1:0] cy_next;
    logic signed [Z_W-1:0]  z_reg;
    logic signed [Z_W-1:0]  z_next;
    logic                   cy_neg;
    logic [CY_W-1:0]        cy_abs;
    logic [CY_W-1:0]        dx;
    logic [CX_W-1:0]        dy;
    logic [17:0]            y_init;

    // The x term only ever grows, and the y step truncates towards zero, so
    // the y shift works on its magnitude.
    always_comb
    begin
        cy_neg  = cy_reg[CY_W-1];
        cy_abs  = cy_neg ? CY_W'(-cy_reg) : CY_W'(cy_reg);
        dx      = cy_abs >> idx;
        dy      = cx_reg >> idx;
        y_init  = 18'(mag) * BEAR_GAIN;
        cx_next = cx_reg;
        cy_next = cy_reg;
        z_next  = z_reg;
        if (ctl.load)
        begin
            cx_next = CORDIC_X0;
            cy_next = signed'({2'b00, y_init, 10'b0});
            z_next  = '0;
        end
        else if (ctl.step)
        begin
            cx_next = cx_reg + dx[CX_W-1:0];
            if (cy_neg)
            begin
                cy_next = cy_reg + signed'({1'b0, dy});
                z_next  = z_reg - signed'({2'b00, atan_q16(idx)});
            end
            else
            begin
                cy_next = cy_reg - signed'({1'b0, dy});
                z_next  = z_reg + signed'({2'b00, atan_q16(idx)});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        z_reg  <= z_next;
    end

    assign angle = z_reg;

endmodule

### rtl/core/blob_range_bearing_estimator.sv
// ----------------------------------------------------------------------------
// Blob range and bearing estimator
// Pinhole range by serial division and bearing by iterative CORDIC, with an
// aspect-ratio test and a per-frame count of accepted blobs.
//
//   Channel   Handshake                   Payload
//   blob      blob_valid / blob_ready     blob (blob_in_t)
//   result    result_valid / result_ready result (blob_out_t)
//   cfg       cfg_valid / cfg_ready       cfg_index, cfg_data
//
// An item passes from transfer through the load state, 22 divider steps
// (which also cover the 17 CORDIC steps) and the final state, which forms the
// result; the quotient loop sets the length of the run. A blob is taken only in idle.
// A finished result waits in the output register; the next blob is taken
// meanwhile and holds in its final step while that register is still full.
// Reset restores the register defaults and clears the count.
// ----------------------------------------------------------------------------
module blob_range_bearing_estimator
    import brbe_pkg::*;
#(
    parameter int MAX_BLOBS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       blob_valid,
    output logic       blob_ready,
    input  blob_in_t   blob,
    output logic       result_valid,
    input  logic       result_ready,
    output blob_out_t  result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_index,
    input  logic [9:0] cfg_data
);

    localparam logic [6:0] COUNT_LIMIT = 7'((MAX_BLOBS < 127) ? MAX_BLOBS : 127);

    brbe_state_t state_reg;
    brbe_state_t state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [8:0]  x_center_reg;
    logic [9:0]  tgt_height_reg;
    logic [9:0]  ratio_low_reg;
    logic [9:0]  ratio_high_reg;
    logic [6:0]  count_reg;
    logic [6:0]  count_next;
    logic        result_valid_reg;
    logic        result_valid_next;
    blob_out_t   result_reg;
    blob_out_t   result_next;
    blob_in_t    item_reg;
    logic        neg_reg;
    logic [14:0] h100_reg;
    logic [18:0] low_reg;
    logic [18:0] high_reg;

    brbe_ctl_t   div_ctl;
    brbe_ctl_t   cor_ctl;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
    logic [QUOT_W-1:0]     quotient;
    logic signed [Z_W-1:0] angle;
    logic [9:0]  col_diff;
    logic [8:0]  col_mag;
    logic        fin_fire;
    logic        ok;
    logic [16:0] q15;
    logic [16:0] q15_sat;

    assign cfg_ready    = 1'b1;
    assign blob_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        fin_fire   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (blob_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_RUN;
                step_next  = '0;
            end
            ST_RUN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                fin_fire = !result_valid_reg || result_ready;
                if (fin_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        col_diff = {1'b0, x_center_reg} - {1'b0, item_reg.blob_x};
        col_mag  = col_diff[9] ? 9'(-col_diff) : col_diff[8:0];
        dividend = 31'(tgt_height_reg) * DIST_NUM2 + 31'(item_reg.blob_height) * DIST_DEN;
        divisor  = 17'(item_reg.blob_height) * DIST_DEN2;
        div_ctl.load = (state_reg == ST_LOAD);
        div_ctl.step = (state_reg == ST_RUN);
        cor_ctl.load = (state_reg == ST_LOAD);
        cor_ctl.step = (state_reg == ST_RUN) && (step_reg < STEP_W'(CORDIC_STEPS));
    end

    brbe_div u_div (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient)
    );

    brbe_cordic u_cordic (
        .clk   (clk),
        .ctl   (cor_ctl),
        .idx   (step_reg),
        .mag   (col_mag),
        .angle (angle)
    );

    always_comb
    begin
        ok = (item_reg.blob_height != '0) && (item_reg.blob_width != '0) &&
             ({4'b0, h100_reg} >= low_reg) && ({4'b0, h100_reg} <= high_reg);
        q15 = (angle > 0) ? 17'((angle + 18'sd1) >>> 1) : '0;
        count_next = count_reg;
        if (ok && (count_reg < COUNT_LIMIT))
        begin
            count_next = count_reg + 1'b1;
        end
        if (neg_reg)
        begin
            q15_sat = (q15 > 17'd32768) ? 17'd32768 : q15;
            result_next.bearing_q15 = signed'(16'(17'd0 - q15_sat));
        end
        else
        begin
            q15_sat = (q15 > 17'd32767) ? 17'd32767 : q15;
            result_next.bearing_q15 = signed'(q15_sat[15:0]);
        end
        result_next.accepted        = ok;
        result_next.distance_q4     = (item_reg.blob_height == '0) ? DIST_MAX : quotient;
        result_next.signature_out   = item_reg.blob_signature;
        result_next.accepted_so_far = count_next;
        result_next.frame_done      = item_reg.frame_last;
        result_valid_next = result_valid_reg;
        if (fin_fire)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= '0;
            x_center_reg     <= 9'd160;
            tgt_height_reg   <= 10'd80;
            ratio_low_reg    <= 10'd190;
            ratio_high_reg   <= 10'd223;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
            if (fin_fire)
            begin
                count_reg <= item_reg.frame_last ? 7'd0 : count_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_X_CENTER:   x_center_reg   <= cfg_data[8:0];
                    CFG_TGT_HEIGHT: tgt_height_reg <= cfg_data;
                    CFG_RATIO_LOW:  ratio_low_reg  <= cfg_data;
                    CFG_RATIO_HIGH: ratio_high_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (blob_valid && blob_ready)
        begin
            item_reg <= blob;
        end
        if (state_reg == ST_LOAD)
        begin
            neg_reg  <= col_diff[9];
            h100_reg <= 15'(item_reg.blob_height) * 15'd100;
            low_reg  <= 19'(ratio_low_reg) * 19'(item_reg.blob_width);
            high_reg <= 19'(ratio_high_reg) * 19'(item_reg.blob_width);
        end
        if (fin_fire)
        begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTH
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_LIMIT)
        else $error("frame count beyond its limit");

    a_load_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (blob_valid && blob_ready) |=> (state_reg == ST_LOAD))
        else $error("accepted blob not loaded");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside the final step");

    a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.frame_done) |-> (count_reg == 7'd0))
        else $error("count not cleared at frame end");
`endif

endmodule
